>>> rtl/core/assert_macros.svh
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lpps_pkg.sv
package lpps_pkg;

  // Tick count width of every wait register.
  localparam int WaitWidth = 10;
  localparam int NumRegs   = 7;
  localparam int CfgIdxW   = 3;

  // Latch bits that commands touch directly.
  localparam logic [7:0] BitTouch     = 8'h01;
  localparam logic [7:0] BitBacklight = 8'h80;
  localparam logic [7:0] LatchOff     = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_HOLD    = 3'd0,
    REG_AFTER_1V8     = 3'd1,
    REG_AFTER_VGP1    = 3'd2,
    REG_AFTER_NEG     = 3'd3,
    REG_AFTER_POS     = 3'd4,
    REG_AFTER_PANEL   = 3'd5,
    REG_BACKLIGHT_OFF = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_POWER_ON  = 3'd1,
    MODE_POWER_OFF = 3'd2,
    MODE_TOUCH     = 3'd3,
    MODE_BACKLIGHT = 3'd4
  } mode_e;

  // Idle, waiting before power-on step 1..7, waiting in power-off.
  typedef enum logic [3:0] {
    STEP_IDLE = 4'd0,
    STEP_ON1  = 4'd1,
    STEP_ON2  = 4'd2,
    STEP_ON3  = 4'd3,
    STEP_ON4  = 4'd4,
    STEP_ON5  = 4'd5,
    STEP_ON6  = 4'd6,
    STEP_ON7  = 4'd7,
    STEP_OFF  = 4'd8
  } step_e;

  typedef logic [WaitWidth-1:0] wait_t;
  typedef logic [NumRegs-1:0][WaitWidth-1:0] cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       level;
  } in_t;

  typedef struct packed {
    logic [7:0] latch;
    logic       busy_res;
    logic       status;
  } out_t;

  // Reset values, highest register first.
  localparam cfg_t CfgReset = {
    WaitWidth'(1), WaitWidth'(120), WaitWidth'(50), WaitWidth'(1),
    WaitWidth'(5), WaitWidth'(1), WaitWidth'(50)
  };

  // A zero wait lasts one tick.
  function automatic wait_t at_least_one(input wait_t w);
    return (w == '0) ? WaitWidth'(1) : w;
  endfunction

  function automatic logic is_busy(input step_e s);
    logic b;
    unique case (s)
      STEP_ON1, STEP_ON2, STEP_ON3, STEP_ON4,
      STEP_ON5, STEP_ON6, STEP_ON7, STEP_OFF: b = 1'b1;
      default:                                b = 1'b0;
    endcase
    return b;
  endfunction

  // Step that follows once the wait of this step ends.
  function automatic step_e step_next(input step_e s);
    step_e n;
    unique case (s)
      STEP_ON1: n = STEP_ON2;
      STEP_ON2: n = STEP_ON3;
      STEP_ON3: n = STEP_ON4;
      STEP_ON4: n = STEP_ON5;
      STEP_ON5: n = STEP_ON6;
      STEP_ON6: n = STEP_ON7;
      default:  n = STEP_IDLE;
    endcase
    return n;
  endfunction

  // Latch value driven when the wait of a power-on step ends.
  function automatic logic [7:0] on_latch(input step_e s);
    logic [7:0] l;
    unique case (s)
      STEP_ON1: l = 8'h04;
      STEP_ON2: l = 8'h0C;
      STEP_ON3: l = 8'h2C;
      STEP_ON4: l = 8'h6C;
      STEP_ON5: l = 8'h6D;
      STEP_ON6: l = 8'h6F;
      STEP_ON7: l = 8'h7F;
      default:  l = LatchOff;
    endcase
    return l;
  endfunction

  // Wait that precedes power-on step s.
  function automatic wait_t wait_before(input step_e s, input cfg_t cfg);
    wait_t w;
    unique case (s)
      STEP_ON1: w = at_least_one(cfg[REG_RESET_HOLD]);
      STEP_ON2: w = at_least_one(cfg[REG_AFTER_1V8]);
      STEP_ON3: w = at_least_one(cfg[REG_AFTER_VGP1]);
      STEP_ON4: w = at_least_one(cfg[REG_AFTER_NEG]);
      STEP_ON5: w = at_least_one(cfg[REG_AFTER_POS]);
      STEP_ON6: w = WaitWidth'(1);
      default:  w = at_least_one(cfg[REG_AFTER_PANEL]);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/lpps_cfg_regs.sv
module lpps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [lpps_pkg::CfgIdxW-1:0]  wr_index_i,
  input  lpps_pkg::wait_t               wr_data_i,
  output lpps_pkg::cfg_t                cfg_o
);
  import lpps_pkg::*;

  cfg_t regs_q;

  // Write the addressed wait register; indexes past the list drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CfgReset;
    end else if (wr_en_i) begin
      for (int i = 0; i < NumRegs; i++) begin
        if (wr_index_i == CfgIdxW'(i)) begin
          regs_q[i] <= wr_data_i;
        end
      end
    end
  end

  assign cfg_o = regs_q;

endmodule

>>> rtl/core/lpps_seq.sv
`include "assert_macros.svh"

module lpps_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  lpps_pkg::in_t  word_i,
  input  lpps_pkg::cfg_t cfg_i,
  output lpps_pkg::out_t word_o
);
  import lpps_pkg::*;

  step_e      step_q, step_d;
  wait_t      cnt_q, cnt_d;
  logic [7:0] latch_q, latch_d;
  logic       status_d;
  logic       busy;
  logic       wait_done;
  out_t       res_q;

  assign busy      = is_busy(step_q);
  assign wait_done = (cnt_q <= WaitWidth'(1));

  // Next sequence step
  always_comb begin
    step_d = step_q;
    if (upd_i) begin
      if (!busy) begin
        step_d = STEP_IDLE;
      end
      unique case (word_i.mode)
        MODE_TICK: begin
          if (busy && wait_done) begin
            step_d = step_next(step_q);
          end
        end
        MODE_POWER_ON: begin
          if (!busy) begin
            step_d = STEP_ON1;
          end
        end
        MODE_POWER_OFF: begin
          if (!busy) begin
            step_d = STEP_OFF;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Latch, wait counter and status
  always_comb begin
    latch_d  = latch_q;
    cnt_d    = cnt_q;
    status_d = 1'b0;
    if (upd_i) begin
      if (!busy) begin
        cnt_d = '0;
      end
      unique case (word_i.mode)
        MODE_TICK: begin
          if (busy) begin
            if (!wait_done) begin
              cnt_d = cnt_q - WaitWidth'(1);
            end else begin
              cnt_d = '0;
              if (step_q == STEP_OFF) begin
                latch_d = LatchOff;
              end else begin
                latch_d = on_latch(step_q);
                if (step_q != STEP_ON7) begin
                  cnt_d = wait_before(step_next(step_q), cfg_i);
                end
              end
            end
          end
        end
        MODE_POWER_ON: begin
          if (busy) begin
            status_d = 1'b1;
          end else begin
            latch_d = LatchOff;
            cnt_d   = wait_before(STEP_ON1, cfg_i);
          end
        end
        MODE_POWER_OFF: begin
          if (busy) begin
            status_d = 1'b1;
          end else begin
            latch_d = latch_q & ~BitBacklight;
            cnt_d   = at_least_one(cfg_i[REG_BACKLIGHT_OFF]);
          end
        end
        MODE_TOUCH, MODE_BACKLIGHT: begin
          if (busy) begin
            status_d = 1'b1;
          end else if (word_i.level) begin
            latch_d = latch_q | ((word_i.mode == MODE_TOUCH) ? BitTouch : BitBacklight);
          end else begin
            latch_d = latch_q & ~((word_i.mode == MODE_TOUCH) ? BitTouch : BitBacklight);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_IDLE;
      cnt_q   <= '0;
      latch_q <= LatchOff;
    end else begin
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      latch_q <= latch_d;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      res_q.latch    <= latch_d;
      res_q.busy_res <= is_busy(step_d);
      res_q.status   <= status_d;
    end
  end

  assign word_o = res_q;

  `ASSERT_IMPL(idle_cnt_zero, clk_i, rst_ni, step_q == STEP_IDLE, cnt_q == '0,
               "wait counter not clear while idle")
  `ASSERT_IMPL(busy_cnt_live, clk_i, rst_ni, busy, cnt_q != '0,
               "wait counter empty while a sequence runs")
  `ASSERT_NEXT(reject_keeps_latch, clk_i, rst_ni, upd_i && status_d,
               latch_q == $past(latch_q) && step_q == $past(step_q),
               "rejected command changed the latch or step")
  `ASSERT_NEXT(power_on_clears, clk_i, rst_ni,
               upd_i && !busy && word_i.mode == MODE_POWER_ON,
               latch_q == LatchOff && step_q == STEP_ON1,
               "power-on did not start from an all-low latch")

endmodule

>>> rtl/core/lcd_panel_power_sequencer.sv
// An accepted word is held in the input register, and its result is captured in the result register.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: asynchronous, active low; clears the latch, sequence step and wait
// counter, empties both registers, and loads every wait register with its default.
module lcd_panel_power_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpps_pkg::in_t                 in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpps_pkg::out_t                out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  lpps_pkg::wait_t               cfg_data_i
);
  import lpps_pkg::*;

  cfg_t cfg;
  in_t  s1_word_q;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic move;
  logic upd;
  logic accept;

  // Advance when the result register is free or being drained
  assign move       = !out_valid_q || !out_stall_i;
  assign upd        = s1_valid_q && move;
  assign in_stall_o = s1_valid_q && !move;
  assign accept     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (upd) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (upd) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Register the incoming word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= in_word_i;
    end
  end

  lpps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .word_o (out_word_o)
  );

  assign out_valid_o = out_valid_q;

endmodule
